### sv/rcoam_pkg.sv
`timescale 1ns / 1ps

package rcoam_pkg;

    localparam int unsigned WidthW   = 16;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned PctW     = 8;
    localparam int unsigned DriveW   = 16;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned InDataW  = 80;
    localparam int unsigned OutDataW = 56;

    // Quotient width: |width difference| times 200 stays below 2**24
    localparam int unsigned QuotW    = 24;
    localparam int unsigned DivCntW  = 5;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_AUX_LOW      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_AUX_HIGH     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_THROTTLE_MIN = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_THROTTLE_MAX = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_RUDDER_LEFT  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RUDDER_RIGHT = 3'd5;

    localparam logic [WidthW-1:0] AUX_LOW_RST      = 16'd1000;
    localparam logic [WidthW-1:0] AUX_HIGH_RST     = 16'd2000;
    localparam logic [WidthW-1:0] THROTTLE_MIN_RST = 16'd1000;
    localparam logic [WidthW-1:0] THROTTLE_MAX_RST = 16'd2000;
    localparam logic [WidthW-1:0] RUDDER_LEFT_RST  = 16'd1000;
    localparam logic [WidthW-1:0] RUDDER_RIGHT_RST = 16'd2000;

    localparam logic [7:0]          THR_SCALE    = 8'd100;
    localparam logic [7:0]          RUD_SCALE    = 8'd200;
    localparam logic [TimeW-1:0]    ARM_HOLDOFF  = 32'd5000;
    localparam logic signed [PctW-1:0] STICK_LOW    = 8'sd5;
    localparam logic signed [PctW-1:0] RUDDER_EDGE  = 8'sd95;
    localparam logic signed [PctW-1:0] RUDDER_NEDGE = -8'sd95;
    localparam logic signed [PctW-1:0] PCT_MAX      = 8'sd127;
    localparam logic signed [PctW-1:0] PCT_MIN      = -8'sd127;

    // Divider operand select
    localparam logic SEL_THROTTLE = 1'b0;
    localparam logic SEL_RUDDER   = 1'b1;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_sel;
        logic div_step;
        logic store_t;
        logic store_r;
        logic gesture;
        logic mul_right;
        logic mul_left;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

### sv/rcoam_ctrl.sv
`timescale 1ns / 1ps

module rcoam_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rcoam_pkg::status_t status,
    output rcoam_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_DIV_T  = 3'd2;
    localparam logic [2:0] S_DIV_R  = 3'd3;
    localparam logic [2:0] S_GEST   = 3'd4;
    localparam logic [2:0] S_MUL_R  = 3'd5;
    localparam logic [2:0] S_MUL_L  = 3'd6;
    localparam logic [2:0] S_COMMIT = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                // skip the arithmetic when override is off
                if (status.in_range)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rcoam_pkg::SEL_THROTTLE;
                    state_next    = S_DIV_T;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV_T:
            begin
                if (status.div_done)
                begin
                    cmd.store_t   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = rcoam_pkg::SEL_RUDDER;
                    state_next    = S_DIV_R;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DIV_R:
            begin
                cmd.div_sel = rcoam_pkg::SEL_RUDDER;
                if (status.div_done)
                begin
                    cmd.store_r = 1'b1;
                    state_next  = S_GEST;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            S_GEST:
            begin
                cmd.gesture = 1'b1;
                state_next  = S_MUL_R;
            end
            S_MUL_R:
            begin
                cmd.mul_right = 1'b1;
                state_next    = S_MUL_L;
            end
            S_MUL_L:
            begin
                cmd.mul_left = 1'b1;
                state_next   = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the output register can take the item
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/rcoam_dpath.sv
`timescale 1ns / 1ps

module rcoam_dpath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [rcoam_pkg::InDataW-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rcoam_pkg::OutDataW-1:0]       m_tdata,
    input  logic                                 cfg_valid,
    input  logic [rcoam_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [rcoam_pkg::WidthW-1:0]         cfg_data,
    input  rcoam_pkg::cmd_t                      cmd,
    output rcoam_pkg::status_t                   status
);

    localparam int unsigned W  = rcoam_pkg::WidthW;
    localparam int unsigned QW = rcoam_pkg::QuotW;
    localparam int unsigned PW = rcoam_pkg::PctW;
    localparam int unsigned DW = rcoam_pkg::DriveW;
    localparam int unsigned CW = rcoam_pkg::DivCntW;

    // Configuration registers
    logic [W-1:0] aux_low_reg, aux_high_reg;
    logic [W-1:0] thr_min_reg, thr_max_reg;
    logic [W-1:0] rud_left_reg, rud_right_reg;

    // Captured input item
    logic [W-1:0]                  aux_w_reg, thr_w_reg, rud_w_reg;
    logic [rcoam_pkg::TimeW-1:0]   now_reg;

    // Persistent state
    logic                          armed_state_reg;
    logic [rcoam_pkg::TimeW-1:0]   last_toggle_reg;

    // Divider
    logic [QW-1:0]                 q_reg;
    logic [W-1:0]                  rem_reg;
    logic [W-1:0]                  dvsr_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          neg_reg;
    logic                          zero_reg;
    logic                          sel_reg;

    // Work registers
    logic signed [PW-1:0]          tp_reg, rp_reg;
    logic                          armed_w_reg;
    logic                          toggle_reg;
    logic                          cal_reg;
    logic signed [DW-1:0]          left_reg, right_reg;

    // Output register
    logic                          m_tvalid_reg;
    logic [rcoam_pkg::OutDataW-1:0] m_tdata_reg;

    // Override window
    logic [W:0]   aux_sum;
    logic [W-1:0] aux_thresh;
    logic         in_range;

    assign aux_sum    = {1'b0, aux_low_reg} + {1'b0, aux_high_reg};
    assign aux_thresh = aux_sum[W:1];
    assign in_range   = (aux_w_reg >= aux_thresh) && (aux_w_reg <= aux_high_reg);

    // Divider operands
    logic [W-1:0]        op_w, op_lo, op_hi;
    logic [7:0]          op_k;
    logic signed [W:0]   diff, span;
    logic [W-1:0]        diff_mag, span_mag;
    logic [QW-1:0]       num_mag;

    always_comb
    begin
        if (cmd.div_sel == rcoam_pkg::SEL_RUDDER)
        begin
            op_w  = rud_w_reg;
            op_lo = rud_left_reg;
            op_hi = rud_right_reg;
            op_k  = rcoam_pkg::RUD_SCALE;
        end
        else
        begin
            op_w  = thr_w_reg;
            op_lo = thr_min_reg;
            op_hi = thr_max_reg;
            op_k  = rcoam_pkg::THR_SCALE;
        end
    end

    assign diff     = $signed({1'b0, op_w}) - $signed({1'b0, op_lo});
    assign span     = $signed({1'b0, op_hi}) - $signed({1'b0, op_lo});
    assign diff_mag = diff[W] ? W'(-diff) : diff[W-1:0];
    assign span_mag = span[W] ? W'(-span) : span[W-1:0];
    assign num_mag  = QW'({8'd0, diff_mag} * {16'd0, op_k});

    // One restoring step
    logic [W:0]   rem_sh;
    logic [W:0]   rem_try;
    logic         fits;

    assign rem_sh  = {rem_reg, q_reg[QW-1]};
    assign rem_try = rem_sh - {1'b0, dvsr_reg};
    assign fits    = (rem_sh >= {1'b0, dvsr_reg});

    // Signed quotient, offset and saturation
    logic signed [QW+1:0] q_signed;
    logic signed [QW+1:0] q_off;
    logic signed [PW-1:0] pct_sat;

    always_comb
    begin
        q_signed = neg_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg});
        q_off    = (sel_reg == rcoam_pkg::SEL_RUDDER) ? q_signed - 26'sd100 : q_signed;
        if (zero_reg)
        begin
            pct_sat = '0;
        end
        else if (q_off > 26'sd127)
        begin
            pct_sat = rcoam_pkg::PCT_MAX;
        end
        else if (q_off < -26'sd127)
        begin
            pct_sat = rcoam_pkg::PCT_MIN;
        end
        else
        begin
            pct_sat = q_off[PW-1:0];
        end
    end

    // Gestures
    logic [rcoam_pkg::TimeW-1:0] elapsed;
    logic                        stick_low;
    logic                        arm_gest;
    logic                        cal_gest;

    assign elapsed   = now_reg - last_toggle_reg;
    assign stick_low = (tp_reg < rcoam_pkg::STICK_LOW);
    assign arm_gest  = stick_low && (rp_reg < rcoam_pkg::RUDDER_NEDGE)
                       && (elapsed > rcoam_pkg::ARM_HOLDOFF);
    assign cal_gest  = stick_low && (rp_reg > rcoam_pkg::RUDDER_EDGE);

    // Shared mixer multiplier
    logic signed [PW:0]   rp_ext;
    logic signed [PW:0]   mul_a;
    logic signed [PW+W/2:0] prod;

    assign rp_ext = {rp_reg[PW-1], rp_reg};

    always_comb
    begin
        if (cmd.mul_left)
        begin
            mul_a = (rp_reg > 8'sd0) ? 9'sd100 - rp_ext : 9'sd100;
        end
        else
        begin
            mul_a = (rp_reg < 8'sd0) ? 9'sd100 + rp_ext : 9'sd100;
        end
    end

    assign prod = mul_a * tp_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aux_low_reg   <= rcoam_pkg::AUX_LOW_RST;
            aux_high_reg  <= rcoam_pkg::AUX_HIGH_RST;
            thr_min_reg   <= rcoam_pkg::THROTTLE_MIN_RST;
            thr_max_reg   <= rcoam_pkg::THROTTLE_MAX_RST;
            rud_left_reg  <= rcoam_pkg::RUDDER_LEFT_RST;
            rud_right_reg <= rcoam_pkg::RUDDER_RIGHT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rcoam_pkg::REG_AUX_LOW:      aux_low_reg   <= cfg_data;
                rcoam_pkg::REG_AUX_HIGH:     aux_high_reg  <= cfg_data;
                rcoam_pkg::REG_THROTTLE_MIN: thr_min_reg   <= cfg_data;
                rcoam_pkg::REG_THROTTLE_MAX: thr_max_reg   <= cfg_data;
                rcoam_pkg::REG_RUDDER_LEFT:  rud_left_reg  <= cfg_data;
                rcoam_pkg::REG_RUDDER_RIGHT: rud_right_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            aux_w_reg <= s_tdata[15:0];
            thr_w_reg <= s_tdata[31:16];
            rud_w_reg <= s_tdata[47:32];
            now_reg   <= s_tdata[79:48];
        end

        if (cmd.div_start)
        begin
            q_reg    <= num_mag;
            rem_reg  <= '0;
            dvsr_reg <= span_mag;
            neg_reg  <= diff[W] ^ span[W];
            zero_reg <= (span_mag == '0);
            sel_reg  <= cmd.div_sel;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[QW-2:0], fits};
            rem_reg <= fits ? rem_try[W-1:0] : rem_sh[W-1:0];
        end

        if (cmd.store_t)
        begin
            tp_reg <= pct_sat;
        end
        if (cmd.store_r)
        begin
            rp_reg <= pct_sat;
        end

        if (cmd.gesture)
        begin
            toggle_reg  <= arm_gest;
            cal_reg     <= !arm_gest && cal_gest;
            armed_w_reg <= arm_gest ? !armed_state_reg : armed_state_reg;
            // zero the sticks while disarmed unless a gesture matched
            if (!arm_gest && !cal_gest && !armed_state_reg)
            begin
                tp_reg <= '0;
                rp_reg <= '0;
            end
        end

        if (cmd.mul_right)
        begin
            right_reg <= prod[DW-1:0];
        end
        if (cmd.mul_left)
        begin
            left_reg <= prod[DW-1:0];
        end
    end

    // Divider counter and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            armed_state_reg <= 1'b0;
            last_toggle_reg <= '0;
        end
        else
        begin
            if (cmd.div_start)
            begin
                cnt_reg <= CW'(QW);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end

            if (cmd.commit)
            begin
                if (in_range)
                begin
                    armed_state_reg <= armed_w_reg;
                    if (toggle_reg)
                    begin
                        last_toggle_reg <= now_reg;
                    end
                end
                else
                begin
                    armed_state_reg <= 1'b0;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (in_range)
            begin
                m_tdata_reg <= {5'd0, right_reg, left_reg, rp_reg, tp_reg,
                                cal_reg, armed_w_reg, 1'b1};
            end
            else
            begin
                m_tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.in_range = in_range;
    assign status.div_done = (cnt_reg == '0);
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

### sv/rc_override_arming_mixer.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: aux, throttle, rudder widths, now_ms
// m_*       out        m_tvalid / m_tready  m_tdata: flags, percents, left/right drive
// cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (16-bit register value)
//
// One item at a time. With the aux width inside the override window an item passes
// from acceptance through the 24-step restoring divider, run once for throttle and
// once for rudder, then gesture, mixer and commit steps; otherwise check, then commit.
// The output register holds one finished item, so a new item is taken while it waits;
// a further result holds in the commit step until the register frees.
// rst_n clears state and control asynchronously; configuration returns to its defaults.

module rc_override_arming_mixer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] aux_width, [31:16] throttle_width, [47:32] rudder_width, [79:48] now_ms
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] override_on, [1] armed_out, [2] calibrate_request, [10:3] throttle_pct,
    // [18:11] rudder_pct, [34:19] left_drive, [50:35] right_drive, [55:51] zero
    output logic [55:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    rcoam_pkg::cmd_t    cmd;
    rcoam_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rcoam_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rcoam_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
